// ===== rtl/four_bit_cpu_core_step_assert.svh =====
// assertion macros for the four-bit cpu core step
`ifndef FOUR_BIT_CPU_CORE_STEP_ASSERT_SVH
`define FOUR_BIT_CPU_CORE_STEP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fcs_pkg.sv =====
// types and opcodes shared by the four-bit cpu core step
package fcs_pkg;

    localparam int NibW = 4;
    localparam int PcW  = 8;

    typedef enum logic [3:0] {
        OP_ADD_A  = 4'h0,
        OP_MOV_AB = 4'h1,
        OP_IN_A   = 4'h2,
        OP_MOV_AI = 4'h3,
        OP_MOV_BA = 4'h4,
        OP_ADD_B  = 4'h5,
        OP_IN_B   = 4'h6,
        OP_MOV_BI = 4'h7,
        OP_OUT_B  = 4'h9,
        OP_OUT_I  = 4'hB,
        OP_JNC    = 4'hE,
        OP_JMP    = 4'hF
    } opcode_t;

    typedef struct packed {
        logic [PcW-1:0]  pc;
        logic [NibW-1:0] acc_a;
        logic [NibW-1:0] acc_b;
        logic [NibW-1:0] out_latch;
        logic            carry;
        logic            zero;
    } arch_state_t;

    typedef struct packed {
        arch_state_t st;
        logic        out_write;
        logic        in_taken;
    } exec_result_t;

endpackage

// ===== rtl/fcs_exec.sv =====
// instruction decode and execute for one word
module fcs_exec
    import fcs_pkg::*;
(
    input  arch_state_t          cur,
    input  logic [7:0]           instruction,
    input  logic [NibW-1:0]      in_value,
    output exec_result_t         res
);

    opcode_t         opcode;
    logic [NibW-1:0] imm;
    logic [NibW:0]   sum_a;
    logic [NibW:0]   sum_b;

    assign opcode = opcode_t'(instruction[7:4]);
    assign imm    = instruction[3:0];
    assign sum_a  = {1'b0, cur.acc_a} + {1'b0, imm};
    assign sum_b  = {1'b0, cur.acc_b} + {1'b0, imm};

    always_comb
    begin
        res           = '0;
        res.st        = cur;
        res.st.carry  = 1'b0;
        res.st.zero   = 1'b0;
        res.st.pc     = cur.pc + {{(PcW-1){1'b0}}, 1'b1};
        unique case (opcode)
            OP_ADD_A:
            begin
                res.st.acc_a = sum_a[NibW-1:0];
                res.st.carry = sum_a[NibW];
                res.st.zero  = (sum_a[NibW-1:0] == '0);
            end
            OP_MOV_AB:
            begin
                res.st.acc_a = cur.acc_b;
                res.st.zero  = (cur.acc_b == '0);
            end
            OP_IN_A:
            begin
                res.st.acc_a = in_value;
                res.st.zero  = (in_value == '0);
                res.in_taken = 1'b1;
            end
            OP_MOV_AI:
            begin
                res.st.acc_a = imm;
                res.st.zero  = (imm == '0);
            end
            OP_MOV_BA:
            begin
                res.st.acc_b = cur.acc_a;
                res.st.zero  = (cur.acc_a == '0);
            end
            OP_ADD_B:
            begin
                res.st.acc_b = sum_b[NibW-1:0];
                res.st.carry = sum_b[NibW];
                res.st.zero  = (sum_b[NibW-1:0] == '0);
            end
            OP_IN_B:
            begin
                res.st.acc_b = in_value;
                res.st.zero  = (in_value == '0);
                res.in_taken = 1'b1;
            end
            OP_MOV_BI:
            begin
                res.st.acc_b = imm;
                res.st.zero  = (imm == '0);
            end
            OP_OUT_B:
            begin
                res.st.out_latch = cur.acc_b;
                res.out_write    = 1'b1;
            end
            OP_OUT_I:
            begin
                res.st.out_latch = imm;
                res.out_write    = 1'b1;
            end
            OP_JNC:
            begin
                // carry from the previous instruction
                if (!cur.carry)
                begin
                    res.st.pc = {{(PcW-NibW){1'b0}}, imm};
                end
            end
            OP_JMP:
            begin
                res.st.pc = {{(PcW-NibW){1'b0}}, imm};
            end
            default:
            begin
                // unknown opcode: counter advance only, with carry and zero cleared
            end
        endcase
    end

endmodule

// ===== rtl/four_bit_cpu_core_step.sv =====
// top level of the four-bit cpu core step: input stage, execute, result register
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------------
//  in      | to core   | in_valid / in_stall  | instruction, in_value
//  out     | from core | out_valid / out_stall| fetch_addr, reg_a_value, reg_b_value,
//          |           |                      | out_value, out_write, in_taken,
//          |           |                      | carry_flag, zero_flag
//
//  one word per cycle sustained while out_stall is low; each accepted word is held in the input stage
//  the word is executed against the core registers as it moves from the input
//  stage into the result register, so the next word sees its effects
//  out_stall holds the result register and backs up into in_stall through the input stage
//  reset clears the core registers, the flags and both stage valid bits
`include "four_bit_cpu_core_step_assert.svh"

module four_bit_cpu_core_step
    import fcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       instruction,
    input  logic [NibW-1:0]  in_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PcW-1:0]   fetch_addr,
    output logic [NibW-1:0]  reg_a_value,
    output logic [NibW-1:0]  reg_b_value,
    output logic [NibW-1:0]  out_value,
    output logic             out_write,
    output logic             in_taken,
    output logic             carry_flag,
    output logic             zero_flag
);

    logic            stage_vld_reg;
    logic [7:0]      stage_instr_reg;
    logic [NibW-1:0] stage_in_reg;
    arch_state_t     state_reg;
    logic            res_vld_reg;
    exec_result_t    res_reg;
    exec_result_t    exec_res;
    logic            advance;
    logic            in_accept;

    fcs_exec u_exec (
        .cur         (state_reg),
        .instruction (stage_instr_reg),
        .in_value    (stage_in_reg),
        .res         (exec_res)
    );

    assign advance   = stage_vld_reg && (!res_vld_reg || !out_stall);
    assign in_stall  = stage_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            res_vld_reg   <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                stage_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                res_vld_reg <= 1'b1;
                state_reg   <= exec_res.st;
            end
            else if (!out_stall)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_instr_reg <= instruction;
            stage_in_reg    <= in_value;
        end
        if (advance)
        begin
            res_reg <= exec_res;
        end
    end

    assign out_valid   = res_vld_reg;
    assign fetch_addr  = res_reg.st.pc;
    assign reg_a_value = res_reg.st.acc_a;
    assign reg_b_value = res_reg.st.acc_b;
    assign out_value   = res_reg.st.out_latch;
    assign out_write   = res_reg.out_write;
    assign in_taken    = res_reg.in_taken;
    assign carry_flag  = res_reg.st.carry;
    assign zero_flag   = res_reg.st.zero;

    `FCS_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, res_vld_reg, "result lost")
    `FCS_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, in_accept, stage_vld_reg, "word lost")
    `FCS_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, res_vld_reg && out_stall, "bad stall")
    `FCS_ASSERT_NEXT(a_state_sync, clk, rst_n, advance, state_reg == res_reg.st, "state mismatch")

endmodule
